[rtl/frlpm_pkg.sv]
// ============================================================================
// Flash ring log pointer manager package
// Shared constants, opcode and command codes, controller/datapath structs.
// ============================================================================
package frlpm_pkg;

    localparam int ADDR_W = 19;
    localparam int LEN_W  = 13;
    localparam int SLOT_W = 17;

    localparam logic [ADDR_W-1:0] DATA_BASE   = 19'h10000;
    localparam logic [ADDR_W-1:0] DATA_TOP    = 19'h7FFFF;
    localparam logic [ADDR_W-1:0] SLOT_BASE   = 19'h00000;
    localparam logic [ADDR_W-1:0] RING_SPAN   = 19'h70000;
    localparam logic [LEN_W-1:0]  JRNL_LEN    = 13'd8;
    localparam logic [SLOT_W-1:0] SLOT_STEP   = 17'd8;

    localparam logic [3:0] OP_APPEND      = 4'd0;
    localparam logic [3:0] OP_ACK         = 4'd1;
    localparam logic [3:0] OP_RD_OLDEST   = 4'd2;
    localparam logic [3:0] OP_RD_NEWEST   = 4'd3;
    localparam logic [3:0] OP_READ_FWD    = 4'd4;
    localparam logic [3:0] OP_READ_BWD    = 4'd5;
    localparam logic [3:0] OP_SET_READER  = 4'd6;
    localparam logic [3:0] OP_READ_AT     = 4'd7;
    localparam logic [3:0] OP_ERASE_ALL   = 4'd8;
    localparam logic [3:0] OP_RESTORE     = 4'd9;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_WRITE   = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_ERASE   = 3'd3;
    localparam logic [2:0] CMD_JOURNAL = 3'd4;
    localparam logic [2:0] CMD_CHIP    = 3'd5;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       sum;
        logic       emit;
        logic [1:0] idx;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cnt;
        logic       out_free;
    } t_dp_sts;

endpackage

[rtl/frlpm_if.sv]
// ============================================================================
// Flash ring log pointer manager channel interfaces
// Opcode item channel and flash command result channel, valid/ready.
// ============================================================================
interface frlpm_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [18:0] target_addr;
    logic [12:0] write_len;
    logic [18:0] restore_in;
    logic [18:0] restore_out;
    logic [15:0] restore_slot;
    logic        record_found;

    modport source (
        output valid, opcode, target_addr, write_len, restore_in, restore_out,
               restore_slot, record_found,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_addr, write_len, restore_in, restore_out,
               restore_slot, record_found,
        output ready
    );
endinterface

interface frlpm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [18:0] flash_addr;
    logic [12:0] flash_len;
    logic [18:0] journal_in;
    logic [18:0] journal_out;
    logic        ok;
    logic [18:0] unread_bytes;
    logic [18:0] cursor_addr;
    logic        last;

    modport source (
        output valid, command, flash_addr, flash_len, journal_in, journal_out, ok,
               unread_bytes, cursor_addr, last,
        input  ready
    );
    modport sink (
        input  valid, command, flash_addr, flash_len, journal_in, journal_out, ok,
               unread_bytes, cursor_addr, last,
        output ready
    );
endinterface

[rtl/frlpm_ctrl.sv]
// ============================================================================
// Flash ring log pointer manager controller
// Sequences load, execute, count and emit phases of one item.
// ============================================================================
module frlpm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output frlpm_pkg::t_dp_cmd o_cmd,
    input  frlpm_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SUM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       last_res;

    assign last_res = ({1'b0, r_idx} == (i_sts.cnt - 3'd1));
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.last = last_res;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_idx     = 2'd0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + 2'd1;
                    if (last_res) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

[rtl/frlpm_dp.sv]
// ============================================================================
// Flash ring log pointer manager datapath
// Pointer state, command list build, unread count and output register.
// ============================================================================
module frlpm_dp #(
    parameter int RECORD_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frlpm_pkg::t_dp_cmd i_cmd,
    output frlpm_pkg::t_dp_sts o_sts,
    input  logic [3:0]         i_opcode,
    input  logic [18:0]        i_target_addr,
    input  logic [12:0]        i_write_len,
    input  logic [18:0]        i_restore_in,
    input  logic [18:0]        i_restore_out,
    input  logic [15:0]        i_restore_slot,
    input  logic               i_record_found,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_command,
    output logic [18:0]        o_flash_addr,
    output logic [12:0]        o_flash_len,
    output logic [18:0]        o_journal_in,
    output logic [18:0]        o_journal_out,
    output logic               o_ok,
    output logic [18:0]        o_unread_bytes,
    output logic [18:0]        o_cursor_addr,
    output logic               o_last
);

    localparam logic [12:0] RB_LEN = 13'(RECORD_BYTES);
    localparam logic [19:0] RB_ADD = 20'(RECORD_BYTES);
    localparam logic [18:0] RB_SUB = 19'(RECORD_BYTES);

    logic [3:0]  r_op;
    logic [18:0] r_taddr;
    logic [12:0] r_wlen;
    logic [18:0] r_rin;
    logic [18:0] r_rout;
    logic [15:0] r_rslot;
    logic        r_found;

    logic [18:0] r_wp, n_wp;
    logic [18:0] r_ack, n_ack;
    logic [18:0] r_cur, n_cur;
    logic [16:0] r_slot, n_slot;
    logic        r_ok, n_ok;
    logic [2:0]  r_cnt;
    logic [18:0] r_unread;

    logic [2:0]  r_s_cmd  [4];
    logic [18:0] r_s_addr [4];
    logic [12:0] r_s_len  [4];
    logic [18:0] r_s_jin  [4];
    logic [18:0] r_s_jout [4];

    logic [2:0]  s_cmd  [4];
    logic [18:0] s_addr [4];
    logic [12:0] s_len  [4];
    logic [18:0] s_jin  [4];
    logic [18:0] s_jout [4];
    logic [2:0]  k;
    logic        jrnl;
    logic [16:0] slot_eff;

    logic [19:0] sum_wp, sum_ack, sum_cur;
    logic [18:0] adv_wp, adv_ack, adv_cur;
    logic [18:0] bwd_cur;
    logic [12:0] wlen_cut;
    logic [18:0] diff;

    logic        r_out_valid;

    assign sum_wp  = {1'b0, r_wp}  + RB_ADD;
    assign sum_ack = {1'b0, r_ack} + RB_ADD;
    assign sum_cur = {1'b0, r_cur} + RB_ADD;
    assign adv_wp  = (sum_wp  > {1'b0, frlpm_pkg::DATA_TOP}) ? frlpm_pkg::DATA_BASE
                                                             : sum_wp[18:0];
    assign adv_ack = (sum_ack > {1'b0, frlpm_pkg::DATA_TOP}) ? frlpm_pkg::DATA_BASE
                                                             : sum_ack[18:0];
    assign adv_cur = (sum_cur > {1'b0, frlpm_pkg::DATA_TOP}) ? frlpm_pkg::DATA_BASE
                                                             : sum_cur[18:0];
    // base steps back from the top of the data area (0x80000 wraps to 0)
    assign bwd_cur  = ((r_cur == frlpm_pkg::DATA_BASE) ? 19'd0 : r_cur) - RB_SUB;
    assign wlen_cut = (r_wlen > RB_LEN) ? RB_LEN : r_wlen;

    always_comb begin
        n_wp     = r_wp;
        n_ack    = r_ack;
        n_cur    = r_cur;
        n_slot   = r_slot;
        n_ok     = 1'b1;
        k        = 3'd0;
        jrnl     = 1'b0;
        slot_eff = r_slot;
        for (int i = 0; i < 4; i++) begin
            s_cmd[i]  = frlpm_pkg::CMD_NONE;
            s_addr[i] = '0;
            s_len[i]  = '0;
            s_jin[i]  = '0;
            s_jout[i] = '0;
        end
        case (r_op)
            frlpm_pkg::OP_APPEND: begin
                s_cmd[k[1:0]]  = frlpm_pkg::CMD_WRITE;
                s_addr[k[1:0]] = r_wp;
                s_len[k[1:0]]  = wlen_cut;
                k              = k + 3'd1;
                n_wp           = adv_wp;
                if (adv_wp[15:0] == 16'd0) begin
                    s_cmd[k[1:0]]  = frlpm_pkg::CMD_ERASE;
                    s_addr[k[1:0]] = adv_wp;
                    k              = k + 3'd1;
                end
                jrnl = 1'b1;
            end
            frlpm_pkg::OP_ACK: begin
                if (r_wp != r_ack) begin
                    n_ack = adv_ack;
                    jrnl  = 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            frlpm_pkg::OP_RD_OLDEST: begin
                n_cur = r_ack;
            end
            frlpm_pkg::OP_RD_NEWEST: begin
                n_cur = r_wp;
            end
            frlpm_pkg::OP_READ_FWD: begin
                if (r_wp != r_cur) begin
                    s_cmd[k[1:0]]  = frlpm_pkg::CMD_READ;
                    s_addr[k[1:0]] = r_cur;
                    s_len[k[1:0]]  = RB_LEN;
                    k              = k + 3'd1;
                    n_cur          = adv_cur;
                end else begin
                    n_ok = 1'b0;
                end
            end
            frlpm_pkg::OP_READ_BWD: begin
                if (r_ack != r_cur) begin
                    s_cmd[k[1:0]]  = frlpm_pkg::CMD_READ;
                    s_addr[k[1:0]] = bwd_cur;
                    s_len[k[1:0]]  = RB_LEN;
                    k              = k + 3'd1;
                    n_cur          = bwd_cur;
                end else begin
                    n_ok = 1'b0;
                end
            end
            frlpm_pkg::OP_SET_READER: begin
                if (r_taddr >= r_ack && r_taddr <= r_wp) begin
                    n_cur = r_taddr;
                end else begin
                    n_ok = 1'b0;
                end
            end
            frlpm_pkg::OP_READ_AT: begin
                if (r_cur >= r_ack && r_cur <= r_wp) begin
                    s_cmd[k[1:0]]  = frlpm_pkg::CMD_READ;
                    s_addr[k[1:0]] = r_cur;
                    s_len[k[1:0]]  = RB_LEN;
                    k              = k + 3'd1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            frlpm_pkg::OP_ERASE_ALL: begin
                s_cmd[k[1:0]] = frlpm_pkg::CMD_CHIP;
                k             = k + 3'd1;
                n_wp          = frlpm_pkg::DATA_BASE;
                n_ack         = frlpm_pkg::DATA_BASE;
                n_slot        = '0;
            end
            frlpm_pkg::OP_RESTORE: begin
                if (r_found) begin
                    n_slot = {1'b0, r_rslot} + frlpm_pkg::SLOT_STEP;
                    n_wp   = r_rin;
                    n_ack  = r_rout;
                end else begin
                    s_cmd[k[1:0]]  = frlpm_pkg::CMD_ERASE;
                    s_addr[k[1:0]] = frlpm_pkg::DATA_BASE;
                    k              = k + 3'd1;
                    n_wp           = frlpm_pkg::DATA_BASE;
                    n_ack          = frlpm_pkg::DATA_BASE;
                    n_slot         = '0;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (jrnl) begin
            // slot area full: erase it and restart at slot zero
            if (r_slot[16]) begin
                s_cmd[k[1:0]]  = frlpm_pkg::CMD_ERASE;
                s_addr[k[1:0]] = frlpm_pkg::SLOT_BASE;
                k              = k + 3'd1;
                slot_eff       = '0;
            end
            s_cmd[k[1:0]]  = frlpm_pkg::CMD_JOURNAL;
            s_addr[k[1:0]] = {3'd0, slot_eff[15:0]};
            s_len[k[1:0]]  = frlpm_pkg::JRNL_LEN;
            s_jin[k[1:0]]  = n_wp;
            s_jout[k[1:0]] = n_ack;
            k              = k + 3'd1;
            n_slot         = slot_eff + frlpm_pkg::SLOT_STEP;
        end
        if (k == 3'd0) begin
            k = 3'd1;
        end
    end

    always_comb begin
        diff = r_wp - r_ack;
        if (r_wp < r_ack) begin
            diff = diff + frlpm_pkg::RING_SPAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_taddr <= i_target_addr;
            r_wlen  <= i_write_len;
            r_rin   <= i_restore_in;
            r_rout  <= i_restore_out;
            r_rslot <= i_restore_slot;
            r_found <= i_record_found;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < 4; i++) begin
                r_s_cmd[i]  <= s_cmd[i];
                r_s_addr[i] <= s_addr[i];
                r_s_len[i]  <= s_len[i];
                r_s_jin[i]  <= s_jin[i];
                r_s_jout[i] <= s_jout[i];
            end
            r_ok <= n_ok;
        end
        if (i_cmd.sum) begin
            r_unread <= diff;
        end
        if (i_cmd.emit) begin
            o_command      <= r_s_cmd[i_cmd.idx];
            o_flash_addr   <= r_s_addr[i_cmd.idx];
            o_flash_len    <= r_s_len[i_cmd.idx];
            o_journal_in   <= r_s_jin[i_cmd.idx];
            o_journal_out  <= r_s_jout[i_cmd.idx];
            o_ok           <= r_ok;
            o_unread_bytes <= r_unread;
            o_cursor_addr  <= r_cur;
            o_last         <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= frlpm_pkg::DATA_BASE;
            r_ack       <= frlpm_pkg::DATA_BASE;
            r_cur       <= frlpm_pkg::DATA_BASE;
            r_slot      <= '0;
            r_cnt       <= 3'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_wp   <= n_wp;
                r_ack  <= n_ack;
                r_cur  <= n_cur;
                r_slot <= n_slot;
                r_cnt  <= k;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sts.cnt      = r_cnt;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

[rtl/flash_ring_log_pointer_manager_unit.sv]
// ============================================================================
// Flash ring log pointer manager
// Circular flash log with journaled write/ack pointers and a read cursor.
// ============================================================================
// Usage:
//   i_cmd carries one opcode item (append, acknowledge, cursor moves, reads,
//   set reader, erase all, restore). o_res returns one to four flash command
//   items per opcode item, in order; the final one has last set. Every result
//   reports ok, the unread byte count and the cursor after the whole step.
// Timing:
//   An item is taken in S_IDLE, its command list and pointer update are
//   built in S_EXEC, the unread count is registered in S_SUM, and the
//   results leave one per cycle while the output register is free.
//   The next item is accepted once the last result is loaded, while that
//   result still waits in the output register.
// Reset:
//   Write, ack pointers and cursor go to 0x10000, the journal slot to 0, and
//   the output register empties.
// Stall:
//   A low o_res.ready keeps the current result in the output register and
//   freezes the emit sequence; no result is dropped or repeated.
// ============================================================================
module flash_ring_log_pointer_manager_unit #(
    parameter int RECORD_BYTES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frlpm_in_if.sink     i_cmd,
    frlpm_out_if.source  o_res
);

    frlpm_pkg::t_dp_cmd dp_cmd;
    frlpm_pkg::t_dp_sts dp_sts;

    frlpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    frlpm_dp #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_opcode       (i_cmd.opcode),
        .i_target_addr  (i_cmd.target_addr),
        .i_write_len    (i_cmd.write_len),
        .i_restore_in   (i_cmd.restore_in),
        .i_restore_out  (i_cmd.restore_out),
        .i_restore_slot (i_cmd.restore_slot),
        .i_record_found (i_cmd.record_found),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_command      (o_res.command),
        .o_flash_addr   (o_res.flash_addr),
        .o_flash_len    (o_res.flash_len),
        .o_journal_in   (o_res.journal_in),
        .o_journal_out  (o_res.journal_out),
        .o_ok           (o_res.ok),
        .o_unread_bytes (o_res.unread_bytes),
        .o_cursor_addr  (o_res.cursor_addr),
        .o_last         (o_res.last)
    );

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_sts.out_free)
        else $error("result loaded while output register busy");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !(dp_cmd.exec || dp_cmd.sum || dp_cmd.emit))
        else $error("item accepted while previous item in progress");

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> dp_cmd.exec)
        else $error("accepted item not executed");

    a_exec_then_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.exec |=> (dp_cmd.sum && !dp_cmd.emit))
        else $error("unread count not taken after execute");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> (dp_sts.cnt != 3'd0 && dp_sts.cnt <= 3'd4))
        else $error("result count out of range");

endmodule
